// ===== sv/pnm_pam_stream_writer_core_macros.svh =====
// Assertion macros used by the stream writer RTL.
`ifndef PNM_PAM_STREAM_WRITER_CORE_MACROS_SVH
`define PNM_PAM_STREAM_WRITER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PNM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PNM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pnm_pkg.sv =====
// Types, constants and microcode ROM for the Netpbm stream writer.
package pnm_pkg;

  localparam int PcW = 7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_BYTE,
    OP_NUM,
    OP_PIX,
    OP_END
  } op_t;

  typedef enum logic [1:0] {
    C_NEVER,
    C_ALPHA,
    C_RGB,
    C_ALWAYS
  } cond_t;

  typedef struct packed {
    op_t            op;
    logic [7:0]     arg;
    cond_t          cond;
    logic           quit;
    logic [PcW-1:0] target;
  } ctl_t;

  // Config register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BITS   = 2'd2;
  localparam logic [1:0] REG_ALPHA  = 2'd3;

  // NUM step operand select
  localparam logic [7:0] NUM_W   = 8'd0;
  localparam logic [7:0] NUM_H   = 8'd1;
  localparam logic [7:0] NUM_MAX = 8'd2;

  // Program entry points
  localparam logic [PcW-1:0] PC_HDR = 7'd0;
  localparam logic [PcW-1:0] PC_P7  = 7'd11;
  localparam logic [PcW-1:0] PC_PIX = 7'd75;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  function automatic ctl_t mk(op_t op, logic [7:0] arg, cond_t cond, logic quit,
                              logic [PcW-1:0] target);
    ctl_t c;
    c.op     = op;
    c.arg    = arg;
    c.cond   = cond;
    c.quit   = quit;
    c.target = target;
    return c;
  endfunction

  function automatic ctl_t bw(logic [7:0] b);
    return mk(OP_BYTE, b, C_NEVER, 1'b0, PC_HDR);
  endfunction

  function automatic ctl_t nw(logic [7:0] sel);
    return mk(OP_NUM, sel, C_NEVER, 1'b0, PC_HDR);
  endfunction

  // Microcode: P6 header, P7 header, pixel samples
  function automatic ctl_t ucode(logic [PcW-1:0] a);
    ctl_t c;
    c = mk(OP_END, 8'h00, C_ALWAYS, 1'b1, PC_HDR);
    case (a)
      7'd0:  c = mk(OP_NOP, 8'h00, C_ALPHA, 1'b0, PC_P7);
      7'd1:  c = bw(8'h50);
      7'd2:  c = bw(8'h36);
      7'd3:  c = bw(8'h0a);
      7'd4:  c = nw(NUM_W);
      7'd5:  c = bw(8'h20);
      7'd6:  c = nw(NUM_H);
      7'd7:  c = bw(8'h0a);
      7'd8:  c = nw(NUM_MAX);
      7'd9:  c = bw(8'h0a);
      7'd10: c = mk(OP_END, 8'h00, C_ALWAYS, 1'b1, PC_HDR);
      // P7 magic, tuple type line, then "WIDTH "
      7'd11: c = bw(8'h50);
      7'd12: c = bw(8'h37);
      7'd13: c = bw(8'h0a);
      7'd14: c = bw(8'h54);
      7'd15: c = bw(8'h55);
      7'd16: c = bw(8'h50);
      7'd17: c = bw(8'h4c);
      7'd18: c = bw(8'h54);
      7'd19: c = bw(8'h59);
      7'd20: c = bw(8'h50);
      7'd21: c = bw(8'h45);
      7'd22: c = bw(8'h20);
      7'd23: c = bw(8'h52);
      7'd24: c = bw(8'h47);
      7'd25: c = bw(8'h42);
      7'd26: c = bw(8'h5f);
      7'd27: c = bw(8'h41);
      7'd28: c = bw(8'h4c);
      7'd29: c = bw(8'h50);
      7'd30: c = bw(8'h48);
      7'd31: c = bw(8'h41);
      7'd32: c = bw(8'h0a);
      7'd33: c = bw(8'h57);
      7'd34: c = bw(8'h49);
      7'd35: c = bw(8'h44);
      7'd36: c = bw(8'h54);
      7'd37: c = bw(8'h48);
      7'd38: c = bw(8'h20);
      7'd39: c = nw(NUM_W);
      // "\nHEIGHT "
      7'd40: c = bw(8'h0a);
      7'd41: c = bw(8'h48);
      7'd42: c = bw(8'h45);
      7'd43: c = bw(8'h49);
      7'd44: c = bw(8'h47);
      7'd45: c = bw(8'h48);
      7'd46: c = bw(8'h54);
      7'd47: c = bw(8'h20);
      7'd48: c = nw(NUM_H);
      // "\nMAXVAL "
      7'd49: c = bw(8'h0a);
      7'd50: c = bw(8'h4d);
      7'd51: c = bw(8'h41);
      7'd52: c = bw(8'h58);
      7'd53: c = bw(8'h56);
      7'd54: c = bw(8'h41);
      7'd55: c = bw(8'h4c);
      7'd56: c = bw(8'h20);
      7'd57: c = nw(NUM_MAX);
      // "\nDEPTH 4\nENDHDR\n"
      7'd58: c = bw(8'h0a);
      7'd59: c = bw(8'h44);
      7'd60: c = bw(8'h45);
      7'd61: c = bw(8'h50);
      7'd62: c = bw(8'h54);
      7'd63: c = bw(8'h48);
      7'd64: c = bw(8'h20);
      7'd65: c = bw(8'h34);
      7'd66: c = bw(8'h0a);
      7'd67: c = bw(8'h45);
      7'd68: c = bw(8'h4e);
      7'd69: c = bw(8'h44);
      7'd70: c = bw(8'h48);
      7'd71: c = bw(8'h44);
      7'd72: c = bw(8'h52);
      7'd73: c = bw(8'h0a);
      7'd74: c = mk(OP_END, 8'h00, C_ALWAYS, 1'b1, PC_HDR);
      // Pixel: R, G, B (ends here in RGB mode), A
      7'd75: c = mk(OP_PIX, 8'd0, C_NEVER, 1'b0, PC_HDR);
      7'd76: c = mk(OP_PIX, 8'd1, C_NEVER, 1'b0, PC_HDR);
      7'd77: c = mk(OP_PIX, 8'd2, C_RGB, 1'b1, PC_HDR);
      7'd78: c = mk(OP_PIX, 8'd3, C_ALWAYS, 1'b1, PC_HDR);
      default: c = mk(OP_END, 8'h00, C_ALWAYS, 1'b1, PC_HDR);
    endcase
    return c;
  endfunction

  // Decimal place weight, place 4 = ten thousands
  function automatic logic [16:0] pow10(logic [2:0] place);
    logic [16:0] p;
    case (place)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      default: p = 17'd10000;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/pnm_pam_stream_writer_core.sv =====
// Binary Netpbm (P6 / P7 PAM) stream writer: microcoded sequencer and datapath.
//
// Usage: program frame_width, frame_height, sample_bits and alpha_mode over the
// cfg channel while idle, then pulse start with func = 0 for a frame header and
// func = 1 with pixel_color for each pixel. An item is taken when start is high
// and busy is low. Every result appears on out_word/two_bytes/last_of_run for
// exactly one cycle with result_strobe high; there is no back-pressure, so the
// receiver must take each transfer as it comes. last_of_run flags the final
// transfer of an item. Header bytes come packed two per transfer (earlier byte
// in the high half); an odd final byte comes alone in the low half.
// Timing: one microcode step per cycle while busy, and an item is taken only
// while busy is low, so the next item is taken only after busy drops.
// A pixel takes one step per sample (R, G, B, and A in alpha mode). Headers run
// one step per fixed byte plus one step per decimal place of each number (the
// digit unit resolves one decimal place per cycle), plus a dispatch step and a
// closing step. The last transfer of an item shows up in the cycle busy drops.
module pnm_pam_stream_writer_core #(
  parameter int DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [63:0] pixel_color,
  // result channel
  output logic        result_strobe,
  output logic [15:0] out_word,
  output logic        two_bytes,
  output logic        last_of_run,
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  `include "pnm_pam_stream_writer_core_macros.svh"

  // Only the low DimW bits (DIM_BITS, capped at 16) of a dimension reach the header.
  localparam int DimW = (DIM_BITS < 16) ? DIM_BITS : 16;

  // Config registers
  logic [DimW-1:0] frame_width;
  logic [DimW-1:0] frame_height;
  logic [4:0]      sample_bits;
  logic            alpha_mode;

  // Sequencer
  logic [pnm_pkg::PcW-1:0] pc, pc_next;
  logic                    busy_next;
  pnm_pkg::ctl_t           cw;
  logic                    cond_hit;

  // Item payload
  logic [63:0] pix;

  // Digit unit
  logic        num_act, num_act_next;
  logic [2:0]  place, place_next;
  logic        started, started_next;
  logic [15:0] rem, rem_next;
  logic [2:0]  cur_place;
  logic        cur_started;
  logic [15:0] num_src;
  logic [15:0] num_val;
  logic [16:0] pw;
  logic [16:0] kp;
  logic [16:0] sub;
  logic [3:0]  dig;

  // Byte packer
  logic [1:0] hold_cnt, hold_cnt_next;
  logic [7:0] hold0, hold0_next;
  logic [7:0] hold1, hold1_next;
  logic       byte_en;
  logic [7:0] byte_val;

  // Sample path
  logic [4:0]  eff_bits;
  logic [4:0]  shift;
  logic [15:0] maxval;
  logic [15:0] chan;

  // Result register inputs
  logic        strobe_next;
  logic [15:0] word_next;
  logic        two_next;
  logic        last_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (sample_bits == 5'd0) begin
      eff_bits = 5'd1;
    end else if (sample_bits > 5'd16) begin
      eff_bits = 5'd16;
    end else begin
      eff_bits = sample_bits;
    end
  end

  assign shift  = 5'd16 - eff_bits;
  assign maxval = 16'((17'd1 << eff_bits) - 17'd1);

  assign cw = pnm_pkg::ucode(pc);

  always_comb begin
    case (cw.cond)
      pnm_pkg::C_NEVER:  cond_hit = 1'b0;
      pnm_pkg::C_ALPHA:  cond_hit = alpha_mode;
      pnm_pkg::C_RGB:    cond_hit = ~alpha_mode;
      pnm_pkg::C_ALWAYS: cond_hit = 1'b1;
      default:           cond_hit = 1'b0;
    endcase
  end

  // Digit unit: one decimal place per cycle, most significant first.
  always_comb begin
    case (cw.arg)
      pnm_pkg::NUM_W:   num_src = 16'(frame_width);
      pnm_pkg::NUM_H:   num_src = 16'(frame_height);
      pnm_pkg::NUM_MAX: num_src = maxval;
      default:          num_src = maxval;
    endcase
  end

  assign cur_place   = num_act ? place : 3'd4;
  assign cur_started = num_act ? started : 1'b0;
  assign num_val     = num_act ? rem : num_src;
  assign pw          = pnm_pkg::pow10(cur_place);

  always_comb begin
    dig = 4'd0;
    sub = 17'd0;
    kp  = 17'd0;
    for (int k = 1; k < 10; k++) begin
      kp = pw * 17'(k);
      if ({1'b0, num_val} >= kp) begin
        dig = 4'(k);
        sub = kp;
      end
    end
  end

  assign chan = pix[16 * cw.arg[1:0] +: 16];

  always_comb begin
    pc_next       = pc;
    busy_next     = busy;
    num_act_next  = num_act;
    place_next    = place;
    started_next  = started;
    rem_next      = rem;
    hold_cnt_next = hold_cnt;
    hold0_next    = hold0;
    hold1_next    = hold1;
    byte_en       = 1'b0;
    byte_val      = 8'h00;
    strobe_next   = 1'b0;
    word_next     = out_word;
    two_next      = two_bytes;
    last_next     = last_of_run;

    if (!busy) begin
      if (start) begin
        busy_next    = 1'b1;
        pc_next      = func ? pnm_pkg::PC_PIX : pnm_pkg::PC_HDR;
        num_act_next = 1'b0;
      end
    end else begin
      // sequencing
      if (cw.op == pnm_pkg::OP_NUM && cur_place != 3'd0) begin
        pc_next = pc;
      end else if (cond_hit) begin
        if (cw.quit) begin
          busy_next = 1'b0;
        end else begin
          pc_next = cw.target;
        end
      end else begin
        pc_next = pc + 1'b1;
      end

      case (cw.op)
        pnm_pkg::OP_BYTE: begin
          byte_en  = 1'b1;
          byte_val = cw.arg;
        end
        pnm_pkg::OP_NUM: begin
          byte_en      = (dig != 4'd0) || cur_started || (cur_place == 3'd0);
          byte_val     = pnm_pkg::ASCII_ZERO | {4'd0, dig};
          started_next = cur_started | (dig != 4'd0);
          rem_next     = 16'({1'b0, num_val} - sub);
          num_act_next = (cur_place != 3'd0);
          place_next   = cur_place - 3'd1;
        end
        pnm_pkg::OP_PIX: begin
          strobe_next = 1'b1;
          word_next   = chan >> shift;
          two_next    = (eff_bits > 5'd8);
          last_next   = cond_hit & cw.quit;
        end
        pnm_pkg::OP_END: begin
          // flush whatever the packer holds as the closing transfer
          strobe_next   = 1'b1;
          last_next     = 1'b1;
          hold_cnt_next = 2'd0;
          if (hold_cnt == 2'd2) begin
            word_next = {hold0, hold1};
            two_next  = 1'b1;
          end else begin
            word_next = {8'h00, hold0};
            two_next  = 1'b0;
          end
        end
        default: begin
        end
      endcase

      // pair is sent only once a third byte proves it is not the last
      if (byte_en) begin
        if (hold_cnt == 2'd2) begin
          strobe_next   = 1'b1;
          word_next     = {hold0, hold1};
          two_next      = 1'b1;
          last_next     = 1'b0;
          hold0_next    = byte_val;
          hold_cnt_next = 2'd1;
        end else if (hold_cnt == 2'd1) begin
          hold1_next    = byte_val;
          hold_cnt_next = 2'd2;
        end else begin
          hold0_next    = byte_val;
          hold_cnt_next = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pc            <= pnm_pkg::PC_HDR;
      num_act       <= 1'b0;
      place         <= 3'd0;
      started       <= 1'b0;
      hold_cnt      <= 2'd0;
      result_strobe <= 1'b0;
    end else begin
      busy          <= busy_next;
      pc            <= pc_next;
      num_act       <= num_act_next;
      place         <= place_next;
      started       <= started_next;
      hold_cnt      <= hold_cnt_next;
      result_strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      pix <= pixel_color;
    end
    rem         <= rem_next;
    hold0       <= hold0_next;
    hold1       <= hold1_next;
    out_word    <= word_next;
    two_bytes   <= two_next;
    last_of_run <= last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DimW'(1);
      frame_height <= DimW'(1);
      sample_bits  <= 5'd8;
      alpha_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pnm_pkg::REG_WIDTH:  frame_width  <= cfg_data[DimW-1:0];
        pnm_pkg::REG_HEIGHT: frame_height <= cfg_data[DimW-1:0];
        pnm_pkg::REG_BITS:   sample_bits  <= cfg_data[4:0];
        pnm_pkg::REG_ALPHA:  alpha_mode   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  `PNM_ASSERT_NOW(a_idle_only_last, result_strobe && !busy, last_of_run, "non-final transfer while idle")
  `PNM_ASSERT_NEXT(a_no_result_after_take, start && !busy, !result_strobe, "transfer right after accept")
  `PNM_ASSERT_NOW(a_single_byte_clean, result_strobe && !two_bytes, out_word[15:8] == 8'h00, "dirty high byte")
  `PNM_ASSERT_NOW(a_hold_bound, busy, hold_cnt != 2'd3, "packer overfull")
  `PNM_ASSERT_NOW(a_place_bound, num_act, place <= 3'd3, "digit place out of range")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the P6/P7 stream writer: directed rows, then random phases.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RUN_LIMIT    = 300000; // cycles before the run is declared hung
  localparam int unsigned DRAIN_CYCLES = 8;      // last transfer lands as busy drops
  localparam int unsigned N_PHASES     = 6;
  localparam int unsigned PHASE_ITEMS  = 27;

  // item opcodes on func
  localparam logic FUNC_HDR = 1'b0;
  localparam logic FUNC_PIX = 1'b1;

  // one result transfer; packed as {last, two, word} so typed rows read as 18'hX_WWWW
  typedef struct packed {
    logic        last;
    logic        two;
    logic [15:0] word;
  } out_rec_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_HDR,
    ROW_PIX
  } row_kind_t;

  // directed row: a register write, or an item with n_typed hand-written results
  // (n_typed = 0 means the predictor supplies them)
  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         reg_idx;
    logic [63:0]        data;
    logic [2:0]         n_typed;
    out_rec_t [0:5]     typed;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        func = FUNC_HDR;
  logic [63:0] pixel_color = '0;
  logic        result_strobe;
  logic [15:0] out_word;
  logic        two_bytes;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // shadow of the block's registers, updated on each accepted write transfer
  logic [15:0] sh_width  = 16'd1;
  logic [15:0] sh_height = 16'd1;
  logic [4:0]  sh_bits   = 5'd8;
  logic        sh_alpha  = 1'b0;

  out_rec_t    awaited_words [$];  // results still owed by the block, oldest first
  logic [7:0]  hdr_bytes [$];      // header text under construction
  dir_row_t    rows [$];
  int unsigned bad_count = 0;
  int unsigned cycle_count = 0;

  pnm_pam_stream_writer_core u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .pixel_color   (pixel_color),
    .result_strobe (result_strobe),
    .out_word      (out_word),
    .two_bytes     (two_bytes),
    .last_of_run   (last_of_run),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // sample_bits 0 acts as 1, anything above 16 as 16
  function automatic int unsigned kept_bits();
    if (sh_bits == 5'd0) return 1;
    if (sh_bits > 5'd16) return 16;
    return int'(sh_bits);
  endfunction

  function automatic void put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) hdr_bytes.push_back(s[i]);
  endfunction

  // decimal, no leading zeros; zero still gives one digit
  function automatic void put_decimal(int unsigned v);
    logic [7:0]  rev [$];
    int unsigned n;
    n = v;
    do begin
      rev.push_back(8'h30 + 8'(n % 10));
      n = n / 10;
    end while (n != 0);
    while (rev.size() > 0) hdr_bytes.push_back(rev.pop_back());
  endfunction

  // queue up every result one item should produce
  function automatic void predict_stream(logic fn, logic [63:0] color);
    int unsigned bits;
    int unsigned n_smp;
    int unsigned k;
    out_rec_t    r;
    bits = kept_bits();
    if (fn == FUNC_HDR) begin
      hdr_bytes.delete();
      if (sh_alpha) begin
        // tuple type is the two channel words joined by an underscore
        put_text("P7\nTUPLTYPE RGB");
        hdr_bytes.push_back(8'h5f);
        put_text("ALPHA\nWIDTH ");
        put_decimal(sh_width);
        put_text("\nHEIGHT ");
        put_decimal(sh_height);
        put_text("\nMAXVAL ");
        put_decimal((1 << bits) - 1);
        put_text("\nDEPTH 4\nENDHDR\n");
      end else begin
        put_text("P6\n");
        put_decimal(sh_width);
        put_text(" ");
        put_decimal(sh_height);
        put_text("\n");
        put_decimal((1 << bits) - 1);
        put_text("\n");
      end
      // two bytes per transfer, earlier byte high; odd tail byte alone, low half
      for (k = 0; k < hdr_bytes.size(); k += 2) begin
        if (k + 1 < hdr_bytes.size()) begin
          r.word = {hdr_bytes[k], hdr_bytes[k+1]};
          r.two  = 1'b1;
          r.last = (k + 2 >= hdr_bytes.size());
        end else begin
          r.word = {8'h00, hdr_bytes[k]};
          r.two  = 1'b0;
          r.last = 1'b1;
        end
        awaited_words.push_back(r);
      end
    end else begin
      n_smp = sh_alpha ? 4 : 3;
      for (k = 0; k < n_smp; k++) begin
        r.word = color[16*k +: 16] >> (16 - bits);
        r.two  = (bits > 8);
        r.last = (k == n_smp - 1);
        awaited_words.push_back(r);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // wait out everything in flight; only then is a register write safe
  task automatic settle();
    start <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pnm_pkg::REG_WIDTH:  sh_width  = val;
      pnm_pkg::REG_HEIGHT: sh_height = val;
      pnm_pkg::REG_BITS:   sh_bits   = val[4:0];
      default:             sh_alpha  = val[0];
    endcase
    // drop valid for a cycle so back-to-back writes never double-assign it
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one item transfer; start stays high on return so the next item can follow
  // straight away, or the caller / next gap lowers it
  task automatic send_item(logic fn, logic [63:0] color, logic [2:0] n_typed,
                           out_rec_t [0:5] typed, int unsigned idle_pct);
    int unsigned j;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    func        <= fn;
    pixel_color <= color;
    do @(posedge clk); while (busy);
    if (n_typed == 0) predict_stream(fn, color);
    else for (j = 0; j < n_typed; j++) awaited_words.push_back(typed[j]);
  endtask

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [15:0] val);
    dir_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.data    = {48'h0, val};
    return r;
  endfunction

  function automatic dir_row_t item_row(row_kind_t k, logic [63:0] d, logic [2:0] n,
                                        out_rec_t [0:5] t);
    dir_row_t r;
    r = '0;
    r.kind    = k;
    r.data    = d;
    r.n_typed = n;
    r.typed   = t;
    return r;
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_bits();
    case ($urandom_range(5))
      0:       return 16'd1;
      1:       return 16'd16;
      2:       return 16'd8;
      3:       return 16'd9;
      default: return 16'($urandom_range(0, 31)) | (16'($urandom) & 16'hffe0);
    endcase
  endfunction

  function automatic logic [63:0] pick_color();
    case ($urandom_range(9))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so every strobe is a transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_rec_t want;
    if (!rst && result_strobe) begin
      if (awaited_words.size() == 0) begin
        if (bad_count < 10)
          $display("unexpected transfer: word %h two %b last %b",
                   out_word, two_bytes, last_of_run);
        bad_count++;
      end else begin
        want = awaited_words.pop_front();
        if (out_word !== want.word || two_bytes !== want.two ||
            last_of_run !== want.last) begin
          if (bad_count < 10)
            $display("mismatch: word %h two %b last %b, expected %h %b %b",
                     out_word, two_bytes, last_of_run, want.word, want.two, want.last);
          bad_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned       i;
    int unsigned       ph;
    int unsigned       idle_pct;
    int unsigned       idle_by_phase [N_PHASES];
    logic              fn;

    idle_by_phase = '{0, 62, 18, 62, 0, 18};

    // directed table; typed results are {last, two, word}
    // reset values: 1 x 1, 8 bits, P6 -> "P6\n1 1\n255\n"; color ignored on headers
    rows.push_back(item_row(ROW_HDR, 64'hdead_beef_cafe_f00d, 3'd6,
      {18'h1_5036, 18'h1_0a31, 18'h1_2031, 18'h1_0a32, 18'h1_3535, 18'h2_000a}));
    rows.push_back(item_row(ROW_PIX, '1, 3'd3,
      {18'h0_00ff, 18'h0_00ff, 18'h2_00ff, 18'h0, 18'h0, 18'h0}));
    rows.push_back(item_row(ROW_PIX, '0, 3'd3,
      {18'h0_0000, 18'h0_0000, 18'h2_0000, 18'h0, 18'h0, 18'h0}));
    rows.push_back(item_row(ROW_PIX, 64'h0000_89ab_4567_0123, 3'd0, '0));
    // full 16-bit samples go out big-endian as two bytes
    rows.push_back(cfg_row(pnm_pkg::REG_BITS, 16'd16));
    rows.push_back(item_row(ROW_PIX, 64'hffff_8001_7ffe_0001, 3'd3,
      {18'h1_0001, 18'h1_7ffe, 18'h3_8001, 18'h0, 18'h0, 18'h0}));
    rows.push_back(item_row(ROW_HDR, '0, 3'd0, '0));
    rows.push_back(cfg_row(pnm_pkg::REG_WIDTH, 16'hffff));
    rows.push_back(cfg_row(pnm_pkg::REG_HEIGHT, 16'hffff));
    rows.push_back(item_row(ROW_HDR, '1, 3'd0, '0));
    // zero dimensions print as "0"; zero sample bits acts as one -> maxval 1
    rows.push_back(cfg_row(pnm_pkg::REG_WIDTH, 16'd0));
    rows.push_back(cfg_row(pnm_pkg::REG_HEIGHT, 16'd0));
    rows.push_back(cfg_row(pnm_pkg::REG_BITS, 16'd0));
    rows.push_back(item_row(ROW_HDR, '0, 3'd5,
      {18'h1_5036, 18'h1_0a30, 18'h1_2030, 18'h1_0a31, 18'h2_000a, 18'h0}));
    rows.push_back(item_row(ROW_PIX, '1, 3'd3,
      {18'h0_0001, 18'h0_0001, 18'h2_0001, 18'h0, 18'h0, 18'h0}));
    rows.push_back(item_row(ROW_PIX, 64'h7fff_7fff_8000_7fff, 3'd0, '0));
    // sample bits 31 clamps to 16; alpha on -> four samples, P7 header
    rows.push_back(cfg_row(pnm_pkg::REG_BITS, 16'hffff));
    rows.push_back(cfg_row(pnm_pkg::REG_ALPHA, 16'hffff));
    rows.push_back(item_row(ROW_PIX, 64'hfedc_ba98_7654_3210, 3'd4,
      {18'h1_3210, 18'h1_7654, 18'h1_ba98, 18'h3_fedc, 18'h0, 18'h0}));
    rows.push_back(item_row(ROW_HDR, '0, 3'd0, '0));
    rows.push_back(cfg_row(pnm_pkg::REG_WIDTH, 16'd10000));
    rows.push_back(cfg_row(pnm_pkg::REG_HEIGHT, 16'd9));
    rows.push_back(cfg_row(pnm_pkg::REG_BITS, 16'd9));
    rows.push_back(item_row(ROW_HDR, '0, 3'd0, '0));
    rows.push_back(item_row(ROW_PIX, 64'h8080_0180_ff7f_00ff, 3'd0, '0));
    rows.push_back(cfg_row(pnm_pkg::REG_BITS, 16'd12));
    rows.push_back(cfg_row(pnm_pkg::REG_ALPHA, 16'hfffe));
    rows.push_back(item_row(ROW_PIX, 64'h1234_5678_9abc_def0, 3'd0, '0));
    rows.push_back(item_row(ROW_HDR, '0, 3'd0, '0));
    rows.push_back(cfg_row(pnm_pkg::REG_BITS, 16'd7));
    rows.push_back(cfg_row(pnm_pkg::REG_WIDTH, 16'd100));
    rows.push_back(cfg_row(pnm_pkg::REG_HEIGHT, 16'd65534));
    rows.push_back(item_row(ROW_HDR, '0, 3'd0, '0));
    rows.push_back(item_row(ROW_PIX, 64'h0123_4567_89ab_cdef, 3'd0, '0));

    while (rst) @(posedge clk);

    // directed pass, no idling; register rows wait for the pipe to empty
    for (i = 0; i < rows.size(); i++) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(rows[i].reg_idx, rows[i].data[15:0]);
      end else begin
        fn = (rows[i].kind == ROW_PIX) ? FUNC_PIX : FUNC_HDR;
        send_item(fn, rows[i].data, rows[i].n_typed, rows[i].typed, 0);
      end
    end

    // random phases: fresh settings each time, sender idling varies by phase
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      write_reg(pnm_pkg::REG_WIDTH,  pick_dim());
      write_reg(pnm_pkg::REG_HEIGHT, pick_dim());
      write_reg(pnm_pkg::REG_BITS,   pick_bits());
      write_reg(pnm_pkg::REG_ALPHA,  16'($urandom));
      idle_pct = idle_by_phase[ph];
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // headers are rare in a real stream; mostly pixels
        fn = ($urandom_range(7) == 0) ? FUNC_HDR : FUNC_PIX;
        send_item(fn, pick_color(), 3'd0, '0, idle_pct);
      end
    end

    start <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);

    if (bad_count == 0 && awaited_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
